// ----- hdl/pbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pbs_pkg
// shared types and constants of the paged bitmap shifter
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int BYTE_W      = 8;
  localparam int OFFX_W      = 8;
  localparam int OFFY_W      = 7;
  localparam int CFG_IDX_W   = 1;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam logic     CMD_WRITE    = 1'b0;
  localparam logic     CMD_READ     = 1'b1;
  localparam cfg_idx_t CFG_OFFSET_X = 1'b0;
  localparam cfg_idx_t CFG_OFFSET_Y = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/pbs_ram.sv -----
// ----------------------------------------------------------------------------
// pbs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/paged_bitmap_shift_top.sv -----
// ----------------------------------------------------------------------------
// paged_bitmap_shift_top
// page-layout monochrome image store with clipped x/y translation on read
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     tuser command, tdata address+write_byte
//  m_*      out  m_tvalid / m_tready     tdata read_byte
//  cfg_*    in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  a write transfer puts the byte into the ram at accept
//  a read transfer first splits the address into page and column, then the
//  single ram read port is used twice for the two source pages it straddles
//  a pending result stalls the sequencer in its last step until taken
//  rst clears control and offsets; the image store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module paged_bitmap_shift_top #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [0:0]  s_tuser,   // command
  input  wire logic [23:0] s_tdata,   // address[9:0], write_byte[17:10], zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // read_byte
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int PAGES       = HEIGHT / 8;
  localparam int IMAGE_BYTES = WIDTH * PAGES;
  localparam int SW          = $clog2(WIDTH * (PAGES + 2) + 1024) + 1;
  localparam int PGW         = $clog2(PAGES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_LO   = 3'd2;
  localparam logic [2:0] S_HI   = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;

  logic [2:0]                      state;
  logic [2:0]                      state_next;
  pbs_pkg::addr_t                  address;
  logic signed [pbs_pkg::OFFX_W-1:0] offset_x;
  logic signed [pbs_pkg::OFFY_W-1:0] offset_y;
  logic signed [SW-1:0]            sx;
  logic signed [SW-1:0]            p0;
  logic [2:0]                      shift;
  logic                            in_img;
  logic                            ok_lo;
  logic                            ok_hi_q;
  pbs_pkg::byte_t                  lo_byte;

  logic                            s_accept;
  logic                            ram_we;
  logic                            ram_re;
  pbs_pkg::byte_t                  ram_rdata;

  logic [PGW-1:0]                  page;
  logic [SW-1:0]                   addr_ext;
  logic [SW-1:0]                   col;
  logic signed [SW-1:0]            sx_calc;
  logic signed [SW-1:0]            sy_top;
  logic signed [SW-1:0]            q;
  logic signed [SW-1:0]            idx;
  logic                            q_ok;
  logic                            hold;
  logic [15:0]                     pair;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign ram_we    = s_accept && (s_tuser[0] == pbs_pkg::CMD_WRITE);

  // page and column of the requested byte
  always_comb begin
    addr_ext = SW'(address);
    page     = '0;
    for (int k = 1; k < PAGES; k++) begin
      if (addr_ext >= SW'(k * WIDTH)) begin
        page = PGW'(k);
      end
    end
    col     = addr_ext - SW'(page) * SW'(WIDTH);
    sx_calc = $signed(col) - {{(SW-pbs_pkg::OFFX_W){offset_x[pbs_pkg::OFFX_W-1]}}, offset_x};
    sy_top  = $signed(SW'(page) << 3)
            - {{(SW-pbs_pkg::OFFY_W){offset_y[pbs_pkg::OFFY_W-1]}}, offset_y};
  end

  // shared source address unit, one source page per use
  always_comb begin
    q    = (state == S_HI) ? (p0 + SW'(1)) : p0;
    idx  = q * $signed(SW'(WIDTH)) + sx;
    q_ok = in_img
        && (q >= 0) && (q < $signed(SW'(PAGES)))
        && (sx >= 0) && (sx < $signed(SW'(WIDTH)))
        && (idx < $signed(SW'(pbs_pkg::STORE_DEPTH)));
  end

  assign ram_re = (state == S_LO) || (state == S_HI);
  assign hold   = m_tvalid && !m_tready;
  assign pair   = {(ok_hi_q ? ram_rdata : 8'h00), lo_byte} >> shift;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept && (s_tuser[0] == pbs_pkg::CMD_READ)) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: state_next = S_LO;
      S_LO:   state_next = S_HI;
      S_HI:   state_next = S_CAP;
      S_CAP: begin
        if (!hold) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      offset_x <= '0;
      offset_y <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pbs_pkg::CFG_OFFSET_X: offset_x <= cfg_data;
          pbs_pkg::CFG_OFFSET_Y: offset_y <= cfg_data[pbs_pkg::OFFY_W-1:0];
          default: ;
        endcase
      end
      if ((state == S_CAP) && !hold) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      address <= s_tdata[pbs_pkg::ADDR_W-1:0];
    end
    case (state)
      S_ADDR: begin
        sx     <= sx_calc;
        p0     <= sy_top >>> 3;
        shift  <= sy_top[2:0];
        in_img <= (addr_ext < SW'(IMAGE_BYTES));
      end
      S_LO: ok_lo <= q_ok;
      S_HI: begin
        ok_hi_q <= q_ok;
        lo_byte <= ok_lo ? ram_rdata : 8'h00;
      end
      S_CAP: begin
        if (!hold) begin
          m_tdata <= pair[7:0];
        end
      end
      default: ;
    endcase
  end

  pbs_ram #(
    .DATA_W (pbs_pkg::BYTE_W),
    .DEPTH  (pbs_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_tdata[pbs_pkg::ADDR_W-1:0]),
    .wdata (s_tdata[pbs_pkg::ADDR_W +: pbs_pkg::BYTE_W]),
    .re    (ram_re),
    .raddr (idx[pbs_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- test/paged_bitmap_shift_top_tb.sv -----
// ----------------------------------------------------------------------------
// paged_bitmap_shift_top_tb
// self-checking bench for the paged bitmap shifter
// ----------------------------------------------------------------------------
// loads the whole image first. Each phase then sets the x/y offsets while the
// block is idle and streams shifted reads, plus byte writes in the loop phases.
// Both stream sides idle at random. Every read is predicted from a local copy
// of the image with clipped translation, and each result is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_bitmap_shift_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH       = 128;
  localparam int HEIGHT      = 64;
  localparam int PAGES       = HEIGHT / 8;
  localparam int ROWS        = PAGES * 8;
  localparam int IMAGE_BYTES = WIDTH * PAGES;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic           cmd;
    pbs_pkg::addr_t addr;
    pbs_pkg::byte_t data;
  } bitmap_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [0:0]  s_tuser = pbs_pkg::CMD_WRITE;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = pbs_pkg::CFG_OFFSET_X;
  logic [7:0]  cfg_data = '0;

  bitmap_op_t     op_queue[$];
  pbs_pkg::byte_t shifted_bytes[$];
  bitmap_op_t     op_on_bus;
  pbs_pkg::byte_t image_copy[pbs_pkg::STORE_DEPTH];
  int             shift_x = 0;
  int             shift_y = 0;
  int             src_gap = 0;
  int             sink_stall = 0;
  int             errors = 0;
  bit             steady = 1'b0;

  paged_bitmap_shift_top #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // clipped translation: output pixel (x, y) takes source pixel (x - dx, y - dy)
  function automatic pbs_pkg::byte_t translated_byte(pbs_pkg::addr_t addr);
    int             page, col, sx, sy;
    pbs_pkg::byte_t r;
    r = '0;
    page = addr / WIDTH;
    col = addr % WIDTH;
    if (addr < IMAGE_BYTES) begin
      for (int b = 0; b < 8; b++) begin
        sx = col - shift_x;
        sy = page * 8 + b - shift_y;
        if (sx >= 0 && sx < WIDTH && sy >= 0 && sy < ROWS)
          r[b] = image_copy[(sy / 8) * WIDTH + sx][sy % 8];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (op_on_bus.cmd == pbs_pkg::CMD_WRITE)
          image_copy[op_on_bus.addr] = op_on_bus.data;
        else
          shifted_bytes.push_back(translated_byte(op_on_bus.addr));
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          bitmap_op_t op;
          op = op_queue.pop_front();
          op_on_bus <= op;
          s_tvalid <= 1'b1;
          s_tuser <= op.cmd;
          s_tdata <= {6'b0, op.data, op.addr};
          src_gap <= idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (shifted_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual %02h", $time, m_tdata);
        end else begin
          pbs_pkg::byte_t want;
          want = shifted_bytes.pop_front();
          if (m_tdata !== want) begin
            errors++;
            $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                     $time, want, m_tdata);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) sink_stall <= idle_len();
      end
    end
  end

  task automatic add_op(logic cmd, int addr, int data);
    bitmap_op_t op;
    op.cmd = cmd;
    op.addr = pbs_pkg::addr_t'(addr);
    op.data = pbs_pkg::byte_t'(data);
    op_queue.push_back(op);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (op_queue.size() != 0 || s_tvalid || shifted_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(pbs_pkg::cfg_idx_t idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == pbs_pkg::CFG_OFFSET_X) shift_x = $signed(data);
    else shift_y = $signed(data[6:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_offsets(int ox, int oy);
    write_reg(pbs_pkg::CFG_OFFSET_X, 8'(ox));
    write_reg(pbs_pkg::CFG_OFFSET_Y, {1'($urandom_range(1)), 7'(oy)});
  endtask

  initial begin
    int ox, oy;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_offsets(0, 0);

    // whole image first, corners at all ones
    for (int a = 0; a < pbs_pkg::STORE_DEPTH; a++) begin
      if (a == 0 || a == WIDTH - 1 || a == pbs_pkg::STORE_DEPTH - WIDTH ||
          a == pbs_pkg::STORE_DEPTH - 1)
        add_op(pbs_pkg::CMD_WRITE, a, 8'hff);
      else
        add_op(pbs_pkg::CMD_WRITE, a, $urandom_range(255));
    end
    add_op(pbs_pkg::CMD_READ, 0, 0);
    add_op(pbs_pkg::CMD_READ, WIDTH - 1, 0);
    add_op(pbs_pkg::CMD_READ, pbs_pkg::STORE_DEPTH - WIDTH, 0);
    add_op(pbs_pkg::CMD_READ, pbs_pkg::STORE_DEPTH - 1, 0);
    add_op(pbs_pkg::CMD_WRITE, 5, 8'h00);
    add_op(pbs_pkg::CMD_READ, 5, 0);
    add_op(pbs_pkg::CMD_WRITE, 5, 8'hff);
    add_op(pbs_pkg::CMD_READ, 5, 0);
    add_op(pbs_pkg::CMD_READ, 6, 0);
    wait_drained();

    // extreme offsets: far corner pulls the origin pixel, then all shifted out
    set_offsets(127, 63);
    add_op(pbs_pkg::CMD_READ, pbs_pkg::STORE_DEPTH - 1, 0);
    add_op(pbs_pkg::CMD_READ, 0, 0);
    add_op(pbs_pkg::CMD_READ, 512, 0);
    wait_drained();
    set_offsets(-127, -63);
    add_op(pbs_pkg::CMD_READ, 0, 0);
    add_op(pbs_pkg::CMD_READ, pbs_pkg::STORE_DEPTH - 1, 0);
    wait_drained();
    set_offsets(-128, -64);
    add_op(pbs_pkg::CMD_READ, 0, 0);
    add_op(pbs_pkg::CMD_READ, pbs_pkg::STORE_DEPTH - 1, 0);
    add_op(pbs_pkg::CMD_READ, 300, 0);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          ox = 0;
          oy = 0;
        end
        1: begin
          ox = 127;
          oy = -64;
        end
        2: begin
          ox = -128;
          oy = 63;
        end
        3, 6: begin
          ox = int'($urandom_range(255)) - 128;
          oy = int'($urandom_range(127)) - 64;
        end
        default: begin
          ox = int'($urandom_range(32)) - 16;
          oy = int'($urandom_range(20)) - 10;
        end
      endcase
      steady = (p == 4);
      set_offsets(ox, oy);
      for (int i = 0; i < 34; i++) begin
        if ($urandom_range(99) < 55)
          add_op(pbs_pkg::CMD_READ, $urandom_range(pbs_pkg::STORE_DEPTH - 1), 0);
        else
          add_op(pbs_pkg::CMD_WRITE, $urandom_range(pbs_pkg::STORE_DEPTH - 1),
                 $urandom_range(255));
      end
      wait_drained();
    end

    if (errors == 0)
      $display("** paged_bitmap_shift_top: PASSED **");
    else
      $display("** paged_bitmap_shift_top: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("** paged_bitmap_shift_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/pbs_pkg.sv
hdl/pbs_ram.sv
hdl/paged_bitmap_shift_top.sv
test/paged_bitmap_shift_top_tb.sv
